// ===== design/snfcs_pkg.sv =====
package snfcs_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_COUNT = 1024;

    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int PAGE_CW      = PAGE_SHIFT + 1;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam logic [31:0] TOTAL_BYTES = 32'(SECTOR_BYTES * SECTOR_COUNT);
    localparam logic [11:0] LAST_SECTOR = 12'(SECTOR_COUNT - 1);

    localparam logic [17:0] POLL_LIMIT_RESET = 18'h3ffff;

    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_FREAD = 8'h0b;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] OP_CE    = 8'hc7;
    localparam logic [7:0] OP_WRDI  = 8'h04;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2,
        CMD_ADVANCE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_READ  = 4'b0010,
        MODE_PROG  = 4'b0100,
        MODE_ERASE = 4'b1000
    } t_mode;

    typedef enum logic [4:0] {
        PH_WAIT = 5'b00001,
        PH_POLL = 5'b00010,
        PH_WREN = 5'b00100,
        PH_MAIN = 5'b01000,
        PH_WRDI = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        transaction_valid;
        logic [7:0]  opcode;
        logic [23:0] flash_address;
        logic        address_present;
        logic        dummy_present;
        logic [8:0]  data_bytes;
        logic [23:0] buffer_offset;
        logic        request_done;
        logic        range_error;
        logic        poll_timeout;
    } t_result;

endpackage

// ===== design/spi_nor_flash_command_sequencer.sv =====
// Channel   Handshake              Payload
// request   i_valid / o_ready      i_cmd, i_start_address, i_byte_count, i_first_sector,
//                                  i_second_sector, i_status_byte
// result    o_valid / i_ready      o_transaction_valid ... o_poll_timeout
// config    i_cfg_wr_en            i_cfg_wr_data (poll limit)
//
// One request per cycle when o_ready is high; one result per request, registered.
// The sequencing state and the result register load at the same edge.
// o_ready is high while the result register is empty or being taken.
// Synchronous active-low reset clears the state; poll limit resets to all ones.
module spi_nor_flash_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [17:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [23:0] i_start_address,
    input  logic [24:0] i_byte_count,
    input  logic [11:0] i_first_sector,
    input  logic [11:0] i_second_sector,
    input  logic [7:0]  i_status_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_transaction_valid,
    output logic [7:0]  o_opcode,
    output logic [23:0] o_flash_address,
    output logic        o_address_present,
    output logic        o_dummy_present,
    output logic [8:0]  o_data_bytes,
    output logic [23:0] o_buffer_offset,
    output logic        o_request_done,
    output logic        o_range_error,
    output logic        o_poll_timeout
);

    localparam int PAGE_CW_W = snfcs_pkg::PAGE_CW;

    logic [17:0]             r_poll_limit;
    snfcs_pkg::t_mode        r_mode, n_mode;
    snfcs_pkg::t_phase       r_phase, n_phase;
    snfcs_pkg::t_phase       r_resume, n_resume;
    logic [23:0]             r_addr, n_addr;
    logic [24:0]             r_left, n_left;
    logic [23:0]             r_offset, n_offset;
    logic [11:0]             r_cur, n_cur;
    logic [11:0]             r_end, n_end;
    logic [17:0]             r_polls, n_polls;
    snfcs_pkg::t_result      r_res, n_res;
    logic                    r_out_valid;

    logic                    in_fire;
    snfcs_pkg::t_cmd         cmd;
    logic [25:0]             range_sum;
    logic                    range_bad;
    logic                    sector_bad;
    logic [11:0]             sec_lo, sec_hi;
    logic [PAGE_CW_W-1:0]    room;
    logic [PAGE_CW_W-1:0]    chunk;
    logic                    busy;
    logic                    do_act;
    snfcs_pkg::t_phase       act_ph;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;
    assign cmd     = snfcs_pkg::t_cmd'(i_cmd);
    assign busy    = i_status_byte[0];

    assign range_sum  = {2'b00, i_start_address} + {1'b0, i_byte_count};
    assign range_bad  = (i_byte_count == 25'd0) || (32'(range_sum) > snfcs_pkg::TOTAL_BYTES);
    assign sector_bad = (i_first_sector > snfcs_pkg::LAST_SECTOR)
                     || (i_second_sector > snfcs_pkg::LAST_SECTOR);
    assign sec_lo = (i_first_sector < i_second_sector) ? i_first_sector : i_second_sector;
    assign sec_hi = (i_first_sector < i_second_sector) ? i_second_sector : i_first_sector;

    // Chunk ends at the next page boundary or at the end of the transfer, whichever comes first.
    assign room  = PAGE_CW_W'(snfcs_pkg::PAGE_BYTES)
                 - {1'b0, r_addr[snfcs_pkg::PAGE_SHIFT-1:0]};
    assign chunk = (r_left < 25'(room)) ? r_left[PAGE_CW_W-1:0] : room;

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_resume = r_resume;
        n_addr   = r_addr;
        n_left   = r_left;
        n_offset = r_offset;
        n_cur    = r_cur;
        n_end    = r_end;
        n_polls  = r_polls;
        n_res    = '0;
        do_act   = 1'b0;
        act_ph   = r_phase;

        if (in_fire) begin
            if (cmd != snfcs_pkg::CMD_ADVANCE) begin
                // A start always drops the request in progress.
                n_mode   = snfcs_pkg::MODE_IDLE;
                n_phase  = snfcs_pkg::PH_WAIT;
                n_resume = snfcs_pkg::PH_WAIT;
                if (cmd == snfcs_pkg::CMD_ERASE) begin
                    if (sector_bad) begin
                        n_res.request_done = 1'b1;
                        n_res.range_error  = 1'b1;
                    end else begin
                        n_cur    = sec_lo;
                        n_end    = sec_hi;
                        n_mode   = snfcs_pkg::MODE_ERASE;
                        n_resume = snfcs_pkg::PH_WREN;
                    end
                end else if (range_bad) begin
                    n_res.request_done = 1'b1;
                    n_res.range_error  = 1'b1;
                end else begin
                    n_addr   = i_start_address;
                    n_left   = i_byte_count;
                    n_offset = 24'd0;
                    if (cmd == snfcs_pkg::CMD_READ) begin
                        n_mode   = snfcs_pkg::MODE_READ;
                        n_resume = snfcs_pkg::PH_MAIN;
                    end else begin
                        n_mode   = snfcs_pkg::MODE_PROG;
                        n_resume = snfcs_pkg::PH_WREN;
                    end
                end
            end else if (r_mode != snfcs_pkg::MODE_IDLE) begin
                do_act = 1'b1;
                if (r_phase == snfcs_pkg::PH_POLL) begin
                    if (busy && (r_polls != 18'd0)) begin
                        n_polls                 = r_polls - 18'd1;
                        n_res.transaction_valid = 1'b1;
                        n_res.opcode            = snfcs_pkg::OP_RDSR;
                        n_res.data_bytes        = 9'd1;
                        do_act                  = 1'b0;
                    end else begin
                        n_res.poll_timeout = busy;
                        act_ph             = r_resume;
                        if (r_resume == snfcs_pkg::PH_WAIT) begin
                            n_resume = snfcs_pkg::PH_WREN;
                        end
                    end
                end
            end
        end

        if (do_act) begin
            n_res.transaction_valid = 1'b1;
            unique case (act_ph)
                snfcs_pkg::PH_WAIT: begin
                    n_polls          = (r_poll_limit == 18'd0) ? 18'd0 : r_poll_limit - 18'd1;
                    n_res.opcode     = snfcs_pkg::OP_RDSR;
                    n_res.data_bytes = 9'd1;
                    n_phase          = snfcs_pkg::PH_POLL;
                end
                snfcs_pkg::PH_WREN: begin
                    n_res.opcode = snfcs_pkg::OP_WREN;
                    n_phase      = snfcs_pkg::PH_MAIN;
                end
                snfcs_pkg::PH_MAIN: begin
                    if (r_mode == snfcs_pkg::MODE_ERASE) begin
                        n_phase = snfcs_pkg::PH_WAIT;
                        if ((r_end - r_cur) == snfcs_pkg::LAST_SECTOR) begin
                            n_res.opcode = snfcs_pkg::OP_CE;
                            n_cur        = r_end;
                            n_resume     = snfcs_pkg::PH_WRDI;
                        end else begin
                            n_res.opcode          = snfcs_pkg::OP_SE;
                            n_res.flash_address   = 24'({12'd0, r_cur} << snfcs_pkg::SECTOR_SHIFT);
                            n_res.address_present = 1'b1;
                            if (r_cur == r_end) begin
                                n_resume = snfcs_pkg::PH_WRDI;
                            end else begin
                                n_cur    = r_cur + 12'd1;
                                n_resume = snfcs_pkg::PH_WAIT;
                            end
                        end
                    end else begin
                        n_res.flash_address   = r_addr;
                        n_res.address_present = 1'b1;
                        n_res.data_bytes      = 9'(chunk);
                        n_res.buffer_offset   = r_offset;
                        n_addr                = r_addr + 24'(chunk);
                        n_offset              = r_offset + 24'(chunk);
                        n_left                = r_left - 25'(chunk);
                        n_phase               = snfcs_pkg::PH_WAIT;
                        if (r_mode == snfcs_pkg::MODE_READ) begin
                            n_res.opcode        = snfcs_pkg::OP_FREAD;
                            n_res.dummy_present = 1'b1;
                            if (n_left == 25'd0) begin
                                n_res.request_done = 1'b1;
                                n_mode             = snfcs_pkg::MODE_IDLE;
                                n_resume           = snfcs_pkg::PH_WAIT;
                            end else begin
                                n_resume = snfcs_pkg::PH_MAIN;
                            end
                        end else begin
                            n_res.opcode = snfcs_pkg::OP_PP;
                            n_resume     = (n_left != 25'd0) ? snfcs_pkg::PH_WAIT
                                                             : snfcs_pkg::PH_WRDI;
                        end
                    end
                end
                default: begin
                    n_res.opcode       = snfcs_pkg::OP_WRDI;
                    n_res.request_done = 1'b1;
                    n_mode             = snfcs_pkg::MODE_IDLE;
                    n_phase            = snfcs_pkg::PH_WAIT;
                    n_resume           = snfcs_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= snfcs_pkg::POLL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= snfcs_pkg::MODE_IDLE;
            r_phase     <= snfcs_pkg::PH_WAIT;
            r_resume    <= snfcs_pkg::PH_WAIT;
            r_addr      <= 24'd0;
            r_left      <= 25'd0;
            r_offset    <= 24'd0;
            r_cur       <= 12'd0;
            r_end       <= 12'd0;
            r_polls     <= 18'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_resume <= n_resume;
            r_addr   <= n_addr;
            r_left   <= n_left;
            r_offset <= n_offset;
            r_cur    <= n_cur;
            r_end    <= n_end;
            r_polls  <= n_polls;
            if (o_ready) begin
                r_out_valid <= in_fire;
            end
        end
    end

    // Result payload: load on each accepted request, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_transaction_valid = r_res.transaction_valid;
    assign o_opcode            = r_res.opcode;
    assign o_flash_address     = r_res.flash_address;
    assign o_address_present   = r_res.address_present;
    assign o_dummy_present     = r_res.dummy_present;
    assign o_data_bytes        = r_res.data_bytes;
    assign o_buffer_offset     = r_res.buffer_offset;
    assign o_request_done      = r_res.request_done;
    assign o_range_error       = r_res.range_error;
    assign o_poll_timeout      = r_res.poll_timeout;

endmodule

// ===== design/snfcs_checker.sv =====
module snfcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_cmd,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_transaction_valid,
    input logic [7:0]  o_opcode,
    input logic        o_address_present,
    input logic        o_dummy_present,
    input logic        o_request_done,
    input logic        o_range_error,
    input logic        o_poll_timeout
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_opcode) && $stable(o_request_done))
        else $error("stalled result changed");

    // A start request yields a result with no transaction in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_cmd != snfcs_pkg::CMD_ADVANCE)
        |=> o_valid && !o_transaction_valid && !o_poll_timeout)
        else $error("start request produced a transaction");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_request_done && !o_transaction_valid)
        else $error("rejection without done or with transaction");

    a_dummy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dummy_present
        |-> o_address_present && (o_opcode == snfcs_pkg::OP_FREAD))
        else $error("dummy byte outside fast read");

    // A wait that runs out may be followed directly by the first poll of the next wait.
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_poll_timeout |-> o_transaction_valid)
        else $error("timeout flag on an empty result");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (.*);
